// ===== rtl/core/dlps_pkg.sv =====
// shared constants for the delay line pitch shifter
package dlps_pkg;

    localparam int BUF_SIZE_DEF  = 4096;
    localparam int OVERLAP_DEF   = 256;
    localparam int FRAC_BITS_DEF = 12;

    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 14;
    localparam int WEIGHT_W = 16;

    localparam logic [RATIO_W-1:0]  RATIO_RESET = 14'd4096;
    localparam logic [WEIGHT_W-1:0] ONE_Q15     = 16'h8000;

endpackage

// ===== rtl/core/delay_line_pitch_shifter_unit.sv =====
// dual tap delay line pitch shifter with crossfaded output
//
// Input channel in_valid/in_ready/in_sample carries one Q1.15 audio sample
// per transfer; output channel out_valid/out_ready/out_sample returns one
// crossfaded Q1.15 sample per input, in order. The pitch ratio register
// (unsigned, FRAC_BITS fraction bits) is written over cfg_valid/cfg_ready/
// pitch_ratio; cfg_ready is always high. Writes are to be made only while idle; the block itself does not enforce it.
// Each sample is written to a circular buffer memory with one write port and
// two read ports, and both taps are read in the same cycle, so one sample is
// taken every cycle unless the output stalls. Each sample passes in order
// through the stages buffer read, weight reciprocal multiply, quotient check
// multiply, weight select, tap products and rounding sum.
// All stages advance together; when out_valid is high and out_ready low the
// whole pipeline holds and in_ready goes low in the same cycle.
// Reset clears the pointers, the read position, the fade weight (to one)
// and the pitch ratio (to unity). The buffer is not swept: a fill count marks
// the entries written since reset and unwritten entries read as zero, so the
// block takes samples from the first cycle after reset.
module delay_line_pitch_shifter_unit
    import dlps_pkg::*;
#(
    parameter int BUF_SIZE  = BUF_SIZE_DEF,
    parameter int OVERLAP   = OVERLAP_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [RATIO_W-1:0]  pitch_ratio
);

    localparam int IW    = $clog2(BUF_SIZE);
    localparam int RPW   = IW + FRAC_BITS;
    localparam int SUMW  = ((RPW > RATIO_W) ? RPW : RATIO_W) + 1;
    localparam int HALF  = BUF_SIZE / 2;
    localparam int DW    = $clog2(OVERLAP + 1);
    localparam int G     = 16;
    localparam int PW    = DW + 32;
    localparam logic [63:0] RECIP_W = (64'd1 << 31) / OVERLAP;
    localparam logic [31:0] RECIP   = RECIP_W[31:0];

    typedef enum logic [2:0] {W_KEEP, W_ZERO, W_ONE, W_DIST1, W_DIST2} wmode_t;

    logic signed [SAMPLE_W-1:0] mem [BUF_SIZE];

    logic [RATIO_W-1:0]  pitch_ratio_reg;
    logic [IW-1:0]       wp_reg, wp_next;
    logic [RPW-1:0]      rp_reg, rp_next;
    logic [IW:0]         fill_reg;
    logic [WEIGHT_W-1:0] fade_weight_reg, fade_weight_next;

    logic adv, accept, unity;
    logic [IW-1:0]   t1, t2;
    logic [IW:0]     diff1, diff2;
    logic            c1, c2;
    logic [SUMW-1:0] rp_sum;
    wmode_t          mode_next;
    logic [DW-1:0]   d_next;

    // stage 1
    logic                       v1_reg;
    wmode_t                     mode1_reg;
    logic [DW-1:0]              d1_reg;
    logic signed [SAMPLE_W-1:0] smp1_reg, rda_reg, rdb_reg;
    logic                       fwa1_reg, fwb1_reg, oka1_reg, okb1_reg;
    logic signed [SAMPLE_W-1:0] sa_next, sb_next;
    // stage 2
    logic                       v2_reg;
    wmode_t                     mode2_reg;
    logic [DW-1:0]              d2_reg;
    logic signed [SAMPLE_W-1:0] sa2_reg, sb2_reg;
    logic [PW-1:0]              prod2_reg;
    // stage 3
    logic                       v3_reg;
    wmode_t                     mode3_reg;
    logic [DW-1:0]              d3_reg;
    logic signed [SAMPLE_W-1:0] sa3_reg, sb3_reg;
    logic [15:0]                q03_reg;
    logic [31:0]                qov3_reg;
    logic [15:0]                q0_next;
    logic [31:0]                rem, quo_x;
    logic [15:0]                quo;
    // stage 4
    logic                       v4_reg;
    logic signed [SAMPLE_W-1:0] sa4_reg, sb4_reg;
    // stage 5
    logic                       v5_reg;
    logic signed [31:0]         pa5_reg, pb5_reg, pa_next, pb_next;
    // stage 6
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic signed [31:0]         acc;

    assign adv       = !out_valid_reg || out_ready;
    assign accept    = in_valid && adv;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    assign unity = (32'(pitch_ratio_reg) == (32'd1 << FRAC_BITS));

    // tap addresses and weight decision
    always_comb
    begin
        t1 = rp_reg[RPW-1:FRAC_BITS];
        if (32'(t1) >= 32'(HALF))
        begin
            t2 = IW'(32'(t1) - 32'(HALF));
        end
        else
        begin
            t2 = IW'(32'(t1) + 32'(HALF));
        end
        diff1 = {1'b0, wp_reg} - {1'b0, t1};
        diff2 = {1'b0, wp_reg} - {1'b0, t2};
        c1 = !diff1[IW] && (32'(diff1) <= 32'(OVERLAP));
        c2 = !diff2[IW] && (32'(diff2) <= 32'(OVERLAP));
        mode_next = W_KEEP;
        d_next    = DW'(diff1);
        if (c1 && !unity)
        begin
            mode_next = W_DIST1;
        end
        else if (wp_reg == t1)
        begin
            mode_next = W_ZERO;
        end
        if (c2 && !unity)
        begin
            mode_next = W_DIST2;
            d_next    = DW'(diff2);
        end
        else if (wp_reg == t2)
        begin
            mode_next = W_ONE;
        end
    end

    always_comb
    begin
        wp_next = (32'(wp_reg) == BUF_SIZE - 1) ? '0 : wp_reg + 1'b1;
        rp_sum  = SUMW'(rp_reg) + SUMW'(pitch_ratio_reg);
        if (rp_sum[SUMW-1:FRAC_BITS] >= (SUMW-FRAC_BITS)'(BUF_SIZE))
        begin
            rp_next = '0;
        end
        else
        begin
            rp_next = RPW'(rp_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_ratio_reg <= RATIO_RESET;
            wp_reg          <= '0;
            rp_reg          <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pitch_ratio_reg <= pitch_ratio;
            end
            if (accept)
            begin
                wp_reg <= wp_next;
                rp_reg <= rp_next;
                if (32'(fill_reg) != BUF_SIZE)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // sample buffer, one write and two reads per cycle while the pipeline is not stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_reg] <= in_sample;
        end
        if (adv)
        begin
            rda_reg <= mem[t1];
            rdb_reg <= mem[t2];
        end
    end

    // tap selection with same-step forwarding and unwritten entries as zero
    always_comb
    begin
        sa_next = fwa1_reg ? smp1_reg : (oka1_reg ? rda_reg : '0);
        sb_next = fwb1_reg ? smp1_reg : (okb1_reg ? rdb_reg : '0);
    end

    // quotient correction and weight select
    always_comb
    begin
        q0_next = prod2_reg[G+15:G];
        quo_x   = 32'(d3_reg) << 15;
        rem     = quo_x - qov3_reg;
        quo     = (rem >= 32'(OVERLAP)) ? q03_reg + 1'b1 : q03_reg;
        case (mode3_reg)
            W_KEEP:  fade_weight_next = fade_weight_reg;
            W_ZERO:  fade_weight_next = '0;
            W_ONE:   fade_weight_next = ONE_Q15;
            W_DIST1: fade_weight_next = quo;
            W_DIST2: fade_weight_next = ONE_Q15 - quo;
            default: fade_weight_next = fade_weight_reg;
        endcase
    end

    always_comb
    begin
        pa_next = 32'(sa4_reg) * 32'($signed({1'b0, fade_weight_reg}));
        pb_next = 32'(sb4_reg) * 32'($signed({1'b0, ONE_Q15 - fade_weight_reg}));
        acc     = pa5_reg + pb5_reg + 32'sd16384;
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            fade_weight_reg <= ONE_Q15;
        end
        else if (adv)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= v5_reg;
            if (v3_reg)
            begin
                fade_weight_reg <= fade_weight_next;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= mode_next;
            d1_reg    <= d_next;
            smp1_reg  <= in_sample;
            fwa1_reg  <= (t1 == wp_reg);
            fwb1_reg  <= (t2 == wp_reg);
            oka1_reg  <= ({1'b0, t1} < fill_reg);
            okb1_reg  <= ({1'b0, t2} < fill_reg);

            mode2_reg <= mode1_reg;
            d2_reg    <= d1_reg;
            sa2_reg   <= sa_next;
            sb2_reg   <= sb_next;
            prod2_reg <= PW'(d1_reg) * PW'(RECIP);

            mode3_reg <= mode2_reg;
            d3_reg    <= d2_reg;
            sa3_reg   <= sa2_reg;
            sb3_reg   <= sb2_reg;
            q03_reg   <= q0_next;
            qov3_reg  <= 32'(q0_next) * 32'(OVERLAP);

            sa4_reg   <= sa3_reg;
            sb4_reg   <= sb3_reg;

            pa5_reg   <= pa_next;
            pb5_reg   <= pb_next;

            out_sample_reg <= SAMPLE_W'(acc >>> 15);
        end
    end

endmodule

// ===== rtl/core/dlps_checker.sv =====
// port level checks for the pitch shifter, bound to the top level
module dlps_checker
    import dlps_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_sample,
    input logic                       cfg_valid,
    input logic                       cfg_ready
);

    localparam logic [3:0] PIPE_DEPTH = 4'd6;

    logic [3:0] occ_reg, occ_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample))
        else $error("stalled output changed");

    // no more samples in flight than pipeline stages
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= PIPE_DEPTH)
        else $error("too many samples in flight");

    // every result comes from an accepted sample
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != 4'd0)
        else $error("result without a pending input");

    // input only blocked by an output stall
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output stall");

    // configuration port always takes a transfer
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration transfer refused");

endmodule

bind delay_line_pitch_shifter_unit dlps_checker u_dlps_checker (.*);

// ===== tb/sv/delay_line_pitch_shifter_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the delay line pitch shifter with a built-in output predictor
module delay_line_pitch_shifter_unit_tb;
    import dlps_pkg::*;

    localparam int BUF           = BUF_SIZE_DEF;
    localparam int HALF_BUF      = BUF / 2;
    localparam int OVERLAP       = OVERLAP_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int UNITY         = 1 << 15;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int QUIET_START   = 400;
    localparam int QUIET_END     = 1000;
    localparam int NUM_PHASES    = 8;

    typedef enum logic {PUSH_SAMPLE, SET_RATIO} feed_kind_t;

    typedef struct packed {
        feed_kind_t          kind;
        logic [SAMPLE_W-1:0] value;
    } feed_item_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] in_sample   = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic        [RATIO_W-1:0]  pitch_ratio = '0;

    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;
    int   cycle_count  = 0;
    int   settle_count = 0;
    int   error_count  = 0;

    feed_item_t                 feed_queue [$];
    logic signed [SAMPLE_W-1:0] shifted_outputs [$];

    // predictor state
    logic signed [SAMPLE_W-1:0] line_store [BUF];
    int                         wr_ptr;
    longint                     rd_pos;
    int                         fade;
    logic        [RATIO_W-1:0]  ratio_model;

    wire quiet_stretch = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    delay_line_pitch_shifter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_sample   (in_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .pitch_ratio (pitch_ratio)
    );

    always #1 clk = ~clk;

    function automatic logic signed [SAMPLE_W-1:0] crossfade_next(
        input logic signed [SAMPLE_W-1:0] smp
    );
        int     tap_a;
        int     tap_b;
        int     dist_a;
        int     dist_b;
        bit     unity_ratio;
        longint mix;
        unity_ratio = (int'(ratio_model) == (1 << FRAC));
        line_store[wr_ptr] = smp;
        tap_a = int'(rd_pos >> FRAC);
        if (tap_a >= BUF)
            tap_a = 0;
        tap_b = (tap_a >= HALF_BUF) ? tap_a - HALF_BUF : tap_a + HALF_BUF;
        dist_a = wr_ptr - tap_a;
        if (dist_a >= 0 && dist_a <= OVERLAP && !unity_ratio)
            fade = int'((longint'(dist_a) * UNITY) / OVERLAP);
        else if (dist_a == 0)
            fade = 0;
        dist_b = wr_ptr - tap_b;
        if (dist_b >= 0 && dist_b <= OVERLAP && !unity_ratio)
            fade = UNITY - int'((longint'(dist_b) * UNITY) / OVERLAP);
        else if (dist_b == 0)
            fade = UNITY;
        mix = longint'(line_store[tap_a]) * longint'(fade)
            + longint'(line_store[tap_b]) * longint'(UNITY - fade);
        mix = (mix + longint'(UNITY / 2)) >>> 15;
        rd_pos = rd_pos + longint'(ratio_model);
        wr_ptr = (wr_ptr + 1) % BUF;
        if ((rd_pos >> FRAC) >= BUF)
            rd_pos = 0;
        return mix[SAMPLE_W-1:0];
    endfunction

    task automatic add_sample(input logic [SAMPLE_W-1:0] smp);
        feed_queue.push_back('{PUSH_SAMPLE, smp});
    endtask

    task automatic add_ratio(input int ratio);
        feed_queue.push_back('{SET_RATIO, 16'(ratio)});
    endtask

    // sender: inputs and register writes change on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else if ((in_valid && !in_fire) || (cfg_valid && !cfg_fire))
        begin
            // hold until the transfer happens
        end
        else if (feed_queue.size() == 0)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else if (feed_queue[0].kind == SET_RATIO)
        begin
            in_valid <= 1'b0;
            if (shifted_outputs.size() == 0 && settle_count >= SETTLE_CYCLES)
            begin
                cfg_valid   <= 1'b1;
                pitch_ratio <= feed_queue[0].value[RATIO_W-1:0];
                void'(feed_queue.pop_front());
            end
            else
                cfg_valid <= 1'b0;
        end
        else
        begin
            cfg_valid <= 1'b0;
            if (!quiet_stretch && $urandom_range(99) < 10)
                in_valid <= 1'b0;
            else
            begin
                in_valid  <= 1'b1;
                in_sample <= feed_queue[0].value;
                void'(feed_queue.pop_front());
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (quiet_stretch)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 10);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        in_fire  <= in_valid && in_ready;
        cfg_fire <= cfg_valid && cfg_ready;
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                ratio_model = pitch_ratio;
            if (in_valid && in_ready)
                shifted_outputs.push_back(crossfade_next(in_sample));
            if (out_valid && out_ready)
            begin
                if (shifted_outputs.size() == 0)
                begin
                    $error("out_sample: expected nothing, actual %0d", out_sample);
                    error_count++;
                end
                else
                begin
                    want = shifted_outputs.pop_front();
                    if (out_sample !== want)
                    begin
                        $error("out_sample: expected %0d, actual %0d", want, out_sample);
                        error_count++;
                    end
                end
            end
            if (shifted_outputs.size() == 0 && !in_valid)
                settle_count++;
            else
                settle_count = 0;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("delay_line_pitch_shifter_unit_tb: errors");
        $finish;
    end

    initial
    begin
        int phase_ratio [NUM_PHASES];
        int phase_len [NUM_PHASES];
        logic [SAMPLE_W-1:0] smp;

        for (int i = 0; i < BUF; i++)
            line_store[i] = '0;
        wr_ptr      = 0;
        rd_pos      = 0;
        fade        = UNITY;
        ratio_model = RATIO_RESET;

        // unity ratio from reset: tap sits on the write pointer
        add_sample(16'h7fff);
        add_sample(16'h8000);
        add_sample(16'h0000);
        add_sample(16'hffff);
        add_sample(16'h0001);
        add_sample(16'h5555);
        // frozen read position: write pointer walks into the overlap window
        add_ratio(0);
        add_sample(16'h7fff);
        add_sample(16'h8000);
        add_sample(16'h7fff);
        add_sample(16'h8000);
        add_sample(16'haaaa);
        add_sample(16'hffff);
        // fastest ratio: taps race ahead of the write pointer
        add_ratio(16383);
        add_sample(16'h8000);
        add_sample(16'h7fff);
        add_sample(16'h0001);
        add_sample(16'h8001);
        add_sample(16'h3039);
        add_sample(16'hcfc7);

        phase_ratio = '{0, 4224, 3968, 16383, 4096, 0, 2048, 0};
        phase_len   = '{300, 150, 100, 100, 100, 100, 100, 50};
        phase_ratio[5] = $urandom_range(16383);
        phase_ratio[7] = $urandom_range(16383);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            add_ratio(phase_ratio[p]);
            for (int k = 0; k < phase_len[p]; k++)
            begin
                if ($urandom_range(9) == 0)
                    smp = $urandom_range(1) ? 16'h7fff : 16'h8000;
                else
                    smp = 16'($urandom);
                add_sample(smp);
            end
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (feed_queue.size() != 0 || shifted_outputs.size() != 0 || in_valid || cfg_valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("delay_line_pitch_shifter_unit_tb: clean");
        else
            $display("delay_line_pitch_shifter_unit_tb: errors");
        $finish;
    end

endmodule
